FILE: rtl/node_key_table_fifo_evict_defines.svh
// Assertion macros for the node key table.
// Used by nkt_dpath, the RTL file that asserts; no other dependencies.
`ifndef NODE_KEY_TABLE_FIFO_EVICT_DEFINES_SVH
`define NODE_KEY_TABLE_FIFO_EVICT_DEFINES_SVH

`ifndef SYNTHESIS
`define NKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NKT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NKT_ASSERT(lbl, prop, msg)
`define NKT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/nkt_pkg.sv
// Shared types and constants for the node key table.
// No dependencies.
package nkt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int NODE_W  = 32;
  localparam int WORD_W  = 64;

  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_APPENDED = 3'd1,
    ST_EVICTED = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [WORD_W-1:0] key_w3;
    logic [WORD_W-1:0] key_w2;
    logic [WORD_W-1:0] key_w1;
    logic [WORD_W-1:0] key_w0;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic lookup;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/node_key_table_fifo_evict.sv
// Node key table, FIFO replacement: one item at a time, one result per item.
// The search reads one slot a cycle, and a lookup hit adds a key fetch before the result
// is registered. The next item is taken the cycle after the result is registered,
// even while that result waits on out_stall.
// Reset clears the fill count and age pointer; slot contents stay but are masked by the count.
module node_key_table_fifo_evict (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [nkt_pkg::NODE_W-1:0]  in_node_id,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w0,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w1,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w2,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w3,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w0,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w1,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w2,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w3
);
  import nkt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  nkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  nkt_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_node_id     (in_node_id),
    .in_key_in_w0   (in_key_in_w0),
    .in_key_in_w1   (in_key_in_w1),
    .in_key_in_w2   (in_key_in_w2),
    .in_key_in_w3   (in_key_in_w3),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_key_out_w0 (out_key_out_w0),
    .out_key_out_w1 (out_key_out_w1),
    .out_key_out_w2 (out_key_out_w2),
    .out_key_out_w3 (out_key_out_w3)
  );

endmodule

FILE: rtl/nkt_ctrl.sv
// Sequencer for the node key table: load, scan, optional key fetch, finish.
// Depends on nkt_pkg.
module nkt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output nkt_pkg::dp_cmd_t cmd,
  input  nkt_pkg::dp_sts_t sts
);
  import nkt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (sts.lookup && sts.hit) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/nkt_dpath.sv
// Datapath for the node key table: entry memory, fill count, age pointer,
// search compare and result register. Depends on nkt_pkg and the defines header.
`include "node_key_table_fifo_evict_defines.svh"

module nkt_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_operation,
  input  logic [nkt_pkg::NODE_W-1:0]  in_node_id,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w0,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w1,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w2,
  input  logic [nkt_pkg::WORD_W-1:0]  in_key_in_w3,
  input  nkt_pkg::dp_cmd_t            cmd,
  output nkt_pkg::dp_sts_t            sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w0,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w1,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w2,
  output logic [nkt_pkg::WORD_W-1:0]  out_key_out_w3
);
  import nkt_pkg::*;

  entry_t           mem_r [ENTRIES];
  entry_t           rd_q_r;
  entry_t           item_r;
  op_t              op_r;

  logic [CNT_W-1:0] used_r;
  logic [IDX_W-1:0] oldest_r;
  logic [CNT_W-1:0] scan_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_slot_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_slot_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic [WORD_W-1:0] key0_r, key1_r, key2_r, key3_r;

  logic             scan_issue;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             not_full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             out_free;
  logic             is_hit_now;

  assign scan_issue = cmd.scan && (scan_r < used_r);
  assign rd_en      = scan_issue || cmd.fetch;
  assign rd_addr    = cmd.fetch ? hit_slot_r : scan_r[IDX_W-1:0];
  assign not_full   = (used_r < FULL_CNT);
  assign wr_en      = cmd.finish && (op_r == OP_STORE);
  assign out_free   = !out_valid_r || !out_stall;
  assign is_hit_now = cmp_vld_r && (rd_q_r.node == item_r.node);

  always_comb begin
    if (hit_r) begin
      wr_addr = hit_slot_r;
    end else if (not_full) begin
      wr_addr = used_r[IDX_W-1:0];
    end else begin
      wr_addr = oldest_r;
    end
  end

  always_comb begin
    if (op_r == OP_LOOKUP) begin
      status_nxt = hit_r ? ST_HIT : ST_MISS;
    end else if (hit_r) begin
      status_nxt = ST_UPDATED;
    end else if (not_full) begin
      status_nxt = ST_APPENDED;
    end else begin
      status_nxt = ST_EVICTED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= item_r;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r          <= op_t'(in_operation);
      item_r.node   <= in_node_id;
      item_r.key_w0 <= in_key_in_w0;
      item_r.key_w1 <= in_key_in_w1;
      item_r.key_w2 <= in_key_in_w2;
      item_r.key_w3 <= in_key_in_w3;
    end
    if (scan_issue) begin
      cmp_slot_r <= scan_r[IDX_W-1:0];
    end
    if (is_hit_now) begin
      hit_slot_r <= cmp_slot_r;
    end
    if (cmd.finish) begin
      status_r <= status_nxt;
      if (status_nxt == ST_HIT) begin
        key0_r <= rd_q_r.key_w0;
        key1_r <= rd_q_r.key_w1;
        key2_r <= rd_q_r.key_w2;
        key3_r <= rd_q_r.key_w3;
      end else begin
        key0_r <= '0;
        key1_r <= '0;
        key2_r <= '0;
        key3_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      oldest_r    <= '0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else begin
        cmp_vld_r <= scan_issue;
        if (scan_issue) begin
          scan_r <= scan_r + CNT_W'(1);
        end
        if (is_hit_now) begin
          hit_r <= 1'b1;
        end
      end
      if (wr_en && !hit_r) begin
        if (not_full) begin
          used_r <= used_r + CNT_W'(1);
        end else begin
          // evict: advance the age pointer with wrap
          oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + IDX_W'(1);
        end
      end
    end
  end

  assign sts.scan_done = (scan_r >= used_r) && !cmp_vld_r;
  assign sts.hit       = hit_r;
  assign sts.lookup    = (op_r == OP_LOOKUP);
  assign sts.out_free  = out_free;

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_key_out_w0 = key0_r;
  assign out_key_out_w1 = key1_r;
  assign out_key_out_w2 = key2_r;
  assign out_key_out_w3 = key3_r;

  `NKT_NEVER(a_used_bound, used_r > FULL_CNT, "fill count beyond table size")
  `NKT_ASSERT(a_age_moves_when_full, (rst_n && $past(rst_n) && !$stable(oldest_r)) |-> ($past(used_r) == FULL_CNT), "age pointer moved before table full")
  `NKT_ASSERT(a_finish_free, cmd.finish |-> out_free, "result written over a pending transfer")
  `NKT_ASSERT(a_fetch_on_hit, cmd.fetch |-> (hit_r && op_r == OP_LOOKUP), "key fetch without lookup hit")

endmodule
